>>> rtl/mdh_pkg.sv
// shared types, register map and rounding helpers for the mass damper heun step
// no dependencies; imported by mdh_regs, mdh_front, mdh_queue, mdh_back and the top module

package mdh_pkg;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_INV_MASS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STIFFNESS = 3'd2;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_X     = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z     = 3'd5;

    typedef struct packed {
        logic [30:0]        inv_mass;
        logic [30:0]        damping;
        logic [30:0]        stiffness;
        logic [15:0]        time_step;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_z;
    } cfg_t;

    // nodal differences j - i, kept exact
    typedef struct packed {
        logic signed [32:0] dux;
        logic signed [32:0] duz;
        logic signed [32:0] dvx;
        logic signed [32:0] dvz;
        logic               commit;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DX, ST_DZ, ST_VX, ST_VZ, ST_KE, ST_CV, ST_DV, ST_G1, ST_GM,
        ST_A1, ST_DA, ST_VP, ST_VS, ST_SU, ST_HD, ST_UD, ST_UN, ST_W, ST_KW,
        ST_KQ, ST_G2, ST_GS, ST_GI, ST_AC, ST_DH, ST_VH, ST_VN, ST_DONE
    } seq_state_t;

    // round half up by 2^16 (or 2^17 when half is set), then saturate to 32 bits
    function automatic logic signed [31:0] rnd_sat(input logic signed [66:0] x,
                                                   input logic half);
        logic signed [67:0] xr;
        logic signed [67:0] y;
        xr = 68'(x) + (half ? 68'sd65536 : 68'sd32768);
        y  = half ? (xr >>> 17) : (xr >>> 16);
        if (y > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (y < -68'sd2147483648)
            return 32'sh80000000;
        else
            return y[31:0];
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        if (x > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -34'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

>>> rtl/mdh_item_if.sv
// input channel: nodal displacements, velocities and commit flag
// no dependencies

interface mdh_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] disp_i_x;
    logic signed [31:0] disp_i_z;
    logic signed [31:0] disp_j_x;
    logic signed [31:0] disp_j_z;
    logic signed [31:0] vel_i_x;
    logic signed [31:0] vel_i_z;
    logic signed [31:0] vel_j_x;
    logic signed [31:0] vel_j_z;
    logic               commit;

    modport source (output valid, disp_i_x, disp_i_z, disp_j_x, disp_j_z,
                    vel_i_x, vel_i_z, vel_j_x, vel_j_z, commit, input ready);
    modport sink (input valid, disp_i_x, disp_i_z, disp_j_x, disp_j_z,
                  vel_i_x, vel_i_z, vel_j_x, vel_j_z, commit, output ready);
endinterface

>>> rtl/mdh_result_if.sv
// result channel: spring force, deformation and nodal forces
// no dependencies

interface mdh_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] spring_force;
    logic signed [31:0] deformation;
    logic signed [31:0] force_i_x;
    logic signed [31:0] force_i_z;
    logic signed [31:0] force_j_x;
    logic signed [31:0] force_j_z;

    modport source (output valid, spring_force, deformation, force_i_x, force_i_z,
                    force_j_x, force_j_z, input ready);
    modport sink (input valid, spring_force, deformation, force_i_x, force_i_z,
                  force_j_x, force_j_z, output ready);
endinterface

>>> rtl/mdh_regs.sv
// apb configuration registers with their reset values
// depends on mdh_pkg

module mdh_regs
    import mdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_mass  <= 31'd65536;
            cfg_reg.damping   <= 31'd0;
            cfg_reg.stiffness <= 31'd65536;
            cfg_reg.time_step <= 16'd655;
            cfg_reg.dir_x     <= 18'sd65536;
            cfg_reg.dir_z     <= 18'sd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_INV_MASS:  cfg_reg.inv_mass  <= pwdata[30:0];
                REG_DAMPING:   cfg_reg.damping   <= pwdata[30:0];
                REG_STIFFNESS: cfg_reg.stiffness <= pwdata[30:0];
                REG_TIME_STEP: cfg_reg.time_step <= pwdata[15:0];
                REG_DIR_X:     cfg_reg.dir_x     <= pwdata[17:0];
                REG_DIR_Z:     cfg_reg.dir_z     <= pwdata[17:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INV_MASS:  prdata = {1'b0, cfg_reg.inv_mass};
            REG_DAMPING:   prdata = {1'b0, cfg_reg.damping};
            REG_STIFFNESS: prdata = {1'b0, cfg_reg.stiffness};
            REG_TIME_STEP: prdata = {16'd0, cfg_reg.time_step};
            REG_DIR_X:     prdata = 32'(cfg_reg.dir_x);
            REG_DIR_Z:     prdata = 32'(cfg_reg.dir_z);
            default:       prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/mdh_front.sv
// front stage: takes items and forms the exact nodal differences
// depends on mdh_pkg and mdh_item_if

module mdh_front
    import mdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mdh_item_if.sink   item,
    output entry_t     push_data,
    output logic       push_valid,
    input  logic       push_ready
);

    logic   stage_valid_reg;
    logic   stage_valid_next;
    entry_t stage_reg;
    entry_t stage_next;
    logic   accept;

    assign item.ready = !stage_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign push_valid = stage_valid_reg;
    assign push_data  = stage_reg;

    always_comb
    begin
        stage_next.dux    = 33'(item.disp_j_x) - 33'(item.disp_i_x);
        stage_next.duz    = 33'(item.disp_j_z) - 33'(item.disp_i_z);
        stage_next.dvx    = 33'(item.vel_j_x) - 33'(item.vel_i_x);
        stage_next.dvz    = 33'(item.vel_j_z) - 33'(item.vel_i_z);
        stage_next.commit = item.commit;
        if (accept)
            stage_valid_next = 1'b1;
        else if (push_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

endmodule

>>> rtl/mdh_queue.sv
// short fifo of difference entries between front and back
// depends on mdh_pkg

module mdh_queue
    import mdh_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t push_data,
    input  logic   push_valid,
    output logic   push_ready,
    output entry_t pop_data,
    output logic   pop_valid,
    input  logic   pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone push");

endmodule

>>> rtl/mdh_back.sv
// back sequencer: heun step on one shared 33x33 multiplier, output register
// depends on mdh_pkg and mdh_result_if

module mdh_back
    import mdh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  entry_t       q_data,
    input  logic         q_valid,
    output logic         q_ready,
    mdh_result_if.source result
);

    seq_state_t st_reg, st_next;

    entry_t             ent_reg, ent_next;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] p_reg, p_next;
    logic signed [65:0] s_reg, s_next;
    logic signed [31:0] ue_reg, ue_next, ve_reg, ve_next, e_reg, e_next;
    logic signed [31:0] f_reg, f_next, q_reg, q_next, tdv_reg, tdv_next;
    logic signed [31:0] g1_reg, g1_next, a1_reg, a1_next, vdp_reg, vdp_next;
    logic signed [31:0] cvp_reg, cvp_next, udn_reg, udn_next, w_reg, w_next;
    logic signed [31:0] g2_reg, g2_next, a2_reg, a2_next, vdn_reg, vdn_next;
    logic signed [31:0] fix_reg, fix_next, fiz_reg, fiz_next;
    logic signed [31:0] fjx_reg, fjx_next, fjz_reg, fjz_next;
    logic signed [32:0] vs_reg, vs_next, gs_reg, gs_next;
    logic signed [31:0] ud_reg, ud_next, vd_reg, vd_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;

    logic signed [32:0] k_op, c_op, im_op, dt_op, dx_op, dz_op;

    assign k_op  = $signed({2'b00, cfg.stiffness});
    assign c_op  = $signed({2'b00, cfg.damping});
    assign im_op = $signed({2'b00, cfg.inv_mass});
    assign dt_op = $signed({17'd0, cfg.time_step});
    assign dx_op = 33'(cfg.dir_x);
    assign dz_op = 33'(cfg.dir_z);

    assign q_ready      = (st_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign p_next       = mul_a * mul_b;

    always_comb
    begin
        st_next  = st_reg;
        ent_next = ent_reg;
        mul_a    = '0;
        mul_b    = '0;
        s_next   = s_reg;
        ue_next  = ue_reg;   ve_next  = ve_reg;   e_next   = e_reg;
        f_next   = f_reg;    q_next   = q_reg;    tdv_next = tdv_reg;
        g1_next  = g1_reg;   a1_next  = a1_reg;   vdp_next = vdp_reg;
        cvp_next = cvp_reg;  udn_next = udn_reg;  w_next   = w_reg;
        g2_next  = g2_reg;   a2_next  = a2_reg;   vdn_next = vdn_reg;
        fix_next = fix_reg;  fiz_next = fiz_reg;
        fjx_next = fjx_reg;  fjz_next = fjz_reg;
        vs_next  = vs_reg;   gs_next  = gs_reg;
        ud_next  = ud_reg;   vd_next  = vd_reg;
        out_load = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;

        // each state issues at most one product and may consume the one issued before
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next = q_data;
                    st_next  = ST_DX;
                end
            end
            ST_DX:
            begin
                mul_a = dx_op; mul_b = ent_reg.dux;
                st_next = ST_DZ;
            end
            ST_DZ:
            begin
                s_next = p_reg;
                mul_a = dz_op; mul_b = ent_reg.duz;
                st_next = ST_VX;
            end
            ST_VX:
            begin
                ue_next = rnd_sat(67'(s_reg) + 67'(p_reg), 1'b0);
                mul_a = dx_op; mul_b = ent_reg.dvx;
                st_next = ST_VZ;
            end
            ST_VZ:
            begin
                s_next = p_reg;
                e_next = sat34(34'(ue_reg) - 34'(ud_reg));
                mul_a = dz_op; mul_b = ent_reg.dvz;
                st_next = ST_KE;
            end
            ST_KE:
            begin
                ve_next = rnd_sat(67'(s_reg) + 67'(p_reg), 1'b0);
                mul_a = k_op; mul_b = 33'(e_reg);
                st_next = ST_CV;
            end
            ST_CV:
            begin
                f_next = rnd_sat(67'(p_reg), 1'b0);
                mul_a = c_op; mul_b = 33'(vd_reg);
                st_next = ST_DV;
            end
            ST_DV:
            begin
                q_next = rnd_sat(67'(p_reg), 1'b0);
                mul_a = dt_op; mul_b = 33'(ve_reg);
                st_next = ST_G1;
            end
            ST_G1:
            begin
                tdv_next = rnd_sat(67'(p_reg), 1'b0);
                g1_next  = sat34(34'(f_reg) - 34'(q_reg));
                mul_a = dx_op; mul_b = 33'(f_reg);
                st_next = ST_GM;
            end
            ST_GM:
            begin
                // node j takes +dir*f, node i rounds the negated product
                fjx_next = rnd_sat(67'(p_reg), 1'b0);
                fix_next = rnd_sat(-67'(p_reg), 1'b0);
                mul_a = 33'(g1_reg); mul_b = im_op;
                st_next = ST_A1;
            end
            ST_A1:
            begin
                a1_next = rnd_sat(67'(p_reg), 1'b0);
                mul_a = dz_op; mul_b = 33'(f_reg);
                st_next = ST_DA;
            end
            ST_DA:
            begin
                fjz_next = rnd_sat(67'(p_reg), 1'b0);
                fiz_next = rnd_sat(-67'(p_reg), 1'b0);
                mul_a = dt_op; mul_b = 33'(a1_reg);
                st_next = ST_VP;
            end
            ST_VP:
            begin
                q_next = rnd_sat(67'(p_reg), 1'b0);
                st_next = ST_VS;
            end
            ST_VS:
            begin
                vdp_next = sat34(34'(vd_reg) + 34'(q_reg));
                st_next = ST_SU;
            end
            ST_SU:
            begin
                vs_next = 33'(vd_reg) + 33'(vdp_reg);
                mul_a = c_op; mul_b = 33'(vdp_reg);
                st_next = ST_HD;
            end
            ST_HD:
            begin
                cvp_next = rnd_sat(67'(p_reg), 1'b0);
                mul_a = dt_op; mul_b = vs_reg;
                st_next = ST_UD;
            end
            ST_UD:
            begin
                q_next = rnd_sat(67'(p_reg), 1'b1);
                st_next = ST_UN;
            end
            ST_UN:
            begin
                udn_next = sat34(34'(ud_reg) + 34'(q_reg));
                st_next = ST_W;
            end
            ST_W:
            begin
                w_next = sat34(34'(ue_reg) + 34'(tdv_reg) - 34'(udn_reg));
                st_next = ST_KW;
            end
            ST_KW:
            begin
                mul_a = k_op; mul_b = 33'(w_reg);
                st_next = ST_KQ;
            end
            ST_KQ:
            begin
                q_next = rnd_sat(67'(p_reg), 1'b0);
                st_next = ST_G2;
            end
            ST_G2:
            begin
                g2_next = sat34(34'(q_reg) - 34'(cvp_reg));
                st_next = ST_GS;
            end
            ST_GS:
            begin
                gs_next = 33'(g1_reg) + 33'(g2_reg);
                st_next = ST_GI;
            end
            ST_GI:
            begin
                mul_a = gs_reg; mul_b = im_op;
                st_next = ST_AC;
            end
            ST_AC:
            begin
                a2_next = rnd_sat(67'(p_reg), 1'b0);
                st_next = ST_DH;
            end
            ST_DH:
            begin
                mul_a = dt_op; mul_b = 33'(a2_reg);
                st_next = ST_VH;
            end
            ST_VH:
            begin
                q_next = rnd_sat(67'(p_reg), 1'b1);
                st_next = ST_VN;
            end
            ST_VN:
            begin
                vdn_next = sat34(34'(vd_reg) + 34'(q_reg));
                st_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                    if (ent_reg.commit)
                    begin
                        ud_next = udn_reg;
                        vd_next = vdn_reg;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ud_reg        <= '0;
            vd_reg        <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            ud_reg        <= ud_next;
            vd_reg        <= vd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        p_reg   <= p_next;
        s_reg   <= s_next;
        ue_reg  <= ue_next;   ve_reg  <= ve_next;   e_reg   <= e_next;
        f_reg   <= f_next;    q_reg   <= q_next;    tdv_reg <= tdv_next;
        g1_reg  <= g1_next;   a1_reg  <= a1_next;   vdp_reg <= vdp_next;
        cvp_reg <= cvp_next;  udn_reg <= udn_next;  w_reg   <= w_next;
        g2_reg  <= g2_next;   a2_reg  <= a2_next;   vdn_reg <= vdn_next;
        fix_reg <= fix_next;  fiz_reg <= fiz_next;
        fjx_reg <= fjx_next;  fjz_reg <= fjz_next;
        vs_reg  <= vs_next;   gs_reg  <= gs_next;
        if (out_load)
        begin
            result.spring_force <= f_reg;
            result.deformation  <= ue_reg;
            result.force_i_x    <= fix_reg;
            result.force_i_z    <= fiz_reg;
            result.force_j_x    <= fjx_reg;
            result.force_j_z    <= fjz_reg;
        end
    end

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_DONE) |=> ($stable(ud_reg) && $stable(vd_reg)))
        else $error("damper state changed outside hand-over");

    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE && !q_valid) |=> (st_reg == ST_IDLE))
        else $error("sequencer started without a queued entry");

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while held");

endmodule

>>> rtl/mass_damper_heun_step.sv
// Tuned mass damper element with one Heun step per item. An item is registered in the
// front stage, waits in a QUEUE_DEPTH-entry queue, and then runs in the back sequencer
// (taking the entry in idle, 27 steps, then a hand-over state that waits for a free output
// register); that sequence of dependent products on the single shared 33x33 multiplier
// means the sequencer takes no new entry until it is through with the last. The next item
// may be taken while the previous result waits in the output register. Registers sit on
// the APB port at byte offsets 4*i; write them only while no item is in flight.
// depends on mdh_pkg, mdh_item_if, mdh_result_if and all mdh_* modules

module mass_damper_heun_step
    import mdh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    mdh_item_if.sink          item,
    mdh_result_if.source      result
);

    cfg_t   cfg;
    entry_t push_data;
    logic   push_valid;
    logic   push_ready;
    entry_t pop_data;
    logic   pop_valid;
    logic   pop_ready;

    mdh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    mdh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    mdh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_data  (pop_data),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .result  (result)
    );

endmodule
